// File: rtl/pst_pkg.sv
package pst_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int PID_W   = 5;
    localparam int TIME_W  = 20;
    localparam int TOT_W   = 24;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 120;

    // saturating adds for the time fields
    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {{(TOT_W-TIME_W+1){1'b0}}, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

// File: rtl/pst_ram.sv
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/priority_schedule_times.sv
// priority_schedule_times: non-preemptive priority schedule of one batch.
// Input stream s_*: one beat per process record; s_tdata = {prio_level, burst_len},
// s_tlast marks the last record of the batch. Records are numbered 1 up in arrival
// order; beyond MAX_PROCS records are dropped and the batch is flagged.
// Output stream m_*: one beat per stored process in ascending priority order,
// ties ordered as a plain exchange sort leaves them. Each beat carries id, burst,
// priority, waiting time, turnaround and running totals; m_tlast on the final beat,
// m_tuser set on every beat of a batch that dropped records.
// Sequence: each accepted record that fits is written into the table. After the last
// record of N stored, the sort runs N-1 passes (read entry i, compare it with each
// later entry, write it back), all on the single read port of the process table,
// then each result takes a table read and an output load. s_tready stays low
// from the last record until the final result is loaded into the output register.
// Receiver stall: the output register holds its beat; the emit sequencer waits and
// the next batch may load while the last result still waits.
// Reset: record count, drop flag and sequencer clear, output goes invalid; the
// table itself is not cleared and needs no clearing pass.
module priority_schedule_times
    import pst_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // burst_len[15:0], prio_level[23:16]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // proc_id, burst_out, prio_out, wait_time,
                                             // turnaround, total_wait, total_turnaround,
                                             // zero pad
    output logic                  m_tlast,
    output logic                  m_tuser    // overflow
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int EW = IW + BURST_W + PRIO_W;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1;
    localparam logic [2:0] S_LDI  = 3'd2;
    localparam logic [2:0] S_RDJ  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_WBI  = 3'd5;
    localparam logic [2:0] S_RDK  = 3'd6;
    localparam logic [2:0] S_EMK  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic          ovalid_reg, ovalid_next;

    logic [EW-1:0]      cur_reg, cur_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;
    logic [TOT_W-1:0]   totw_reg, totw_next;
    logic [TOT_W-1:0]   tott_reg, tott_next;
    logic [OUT_DATA_W-1:0] odata_reg, odata_next;
    logic               olast_reg, olast_next;
    logic               ouser_reg, ouser_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic          in_acc;
    logic          full;
    logic [CW-1:0] n_after;
    logic          slot_free;
    logic [TIME_W-1:0] ta;
    logic [TOT_W-1:0]  tw_sum;
    logic [TOT_W-1:0]  tt_sum;
    logic [IW:0]       pid_full;

    pst_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_LOAD);
    assign in_acc    = s_tvalid && s_tready;
    assign full      = (cnt_reg == CW'(MAX_PROCS));
    assign n_after   = full ? cnt_reg : cnt_reg + 1'b1;
    assign slot_free = !ovalid_reg || m_tready;

    assign ta       = sat_time(wait_reg, TIME_W'(ram_rdata[PRIO_W +: BURST_W]));
    assign tw_sum   = sat_tot(totw_reg, wait_reg);
    assign tt_sum   = sat_tot(tott_reg, ta);
    assign pid_full = {1'b0, ram_rdata[EW-1 -: IW]} + 1'b1;

    always_comb
    begin
        case (state_reg)
            S_RDI:   ram_raddr = i_reg;
            S_RDJ:   ram_raddr = j_reg;
            default: ram_raddr = k_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        n_next      = n_reg;
        ovf_next    = ovf_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        wait_next   = wait_reg;
        totw_next   = totw_reg;
        tott_next   = tott_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        ouser_next  = ouser_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[IW-1:0];
        ram_wdata   = {cnt_reg[IW-1:0], s_tdata[BURST_W-1:0],
                       s_tdata[BURST_W +: PRIO_W]};

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next    = n_after;
                        ovf_next  = drop_reg || full;
                        i_next    = '0;
                        k_next    = '0;
                        wait_next = '0;
                        totw_next = '0;
                        tott_next = '0;
                        state_next = (n_after == CW'(1)) ? S_RDK : S_RDI;
                    end
                end
            end
            S_RDI:
            begin
                state_next = S_LDI;
            end
            S_LDI:
            begin
                cur_next   = ram_rdata;
                j_next     = i_reg + 1'b1;
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cur_reg[PRIO_W-1:0] > ram_rdata[PRIO_W-1:0])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
                if (CW'(j_reg) == n_reg - 1'b1)
                begin
                    state_next = S_WBI;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RDJ;
                end
            end
            S_WBI:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = cur_reg;
                if (CW'(i_reg) == n_reg - CW'(2))
                begin
                    state_next = S_RDK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RDI;
                end
            end
            S_RDK:
            begin
                state_next = S_EMK;
            end
            S_EMK:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {3'b000, tt_sum, tw_sum, ta, wait_reg,
                                   ram_rdata[PRIO_W-1:0],
                                   ram_rdata[PRIO_W +: BURST_W],
                                   PID_W'(pid_full)};
                    olast_next  = (CW'(k_reg) == n_reg - 1'b1);
                    ouser_next  = ovf_reg;
                    wait_next   = ta;
                    totw_next   = tw_sum;
                    tott_next   = tt_sum;
                    if (CW'(k_reg) == n_reg - 1'b1)
                    begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RDK;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
            n_reg      <= n_next;
            ovf_reg    <= ovf_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        wait_reg  <= wait_next;
        totw_reg  <= totw_next;
        tott_reg  <= tott_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        ouser_reg <= ouser_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_PROCS))
        else $error("record count beyond table depth");

    a_sort_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg > i_reg) && (CW'(j_reg) < n_reg))
        else $error("sort index out of order or range");

    a_last_stops_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tlast) |=> !s_tready)
        else $error("input still open after last record");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMK && slot_free) |=> m_tvalid)
        else $error("emit did not load output register");

    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMK && slot_free && olast_next) |=> (cnt_reg == '0) && !drop_reg)
        else $error("batch state not cleared after final result");

endmodule

// File: tb/sv/priority_schedule_times_test.sv
module priority_schedule_times_test;

    import pst_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_RECORDS = 225;

    typedef struct {
        bit [PID_W-1:0]   pid;
        bit [BURST_W-1:0] burst;
        bit [PRIO_W-1:0]  prio;
        bit [TIME_W-1:0]  wait_t;
        bit [TIME_W-1:0]  turnaround;
        bit [TOT_W-1:0]   total_wait;
        bit [TOT_W-1:0]   total_turn;
        bit               last;
        bit               overflow;
    } sched_result_t;

    class sched_scoreboard;
        bit [PID_W-1:0]   pid_tab[MAX_PROCS_DEF];
        bit [BURST_W-1:0] burst_tab[MAX_PROCS_DEF];
        bit [PRIO_W-1:0]  prio_tab[MAX_PROCS_DEF];
        int               held;
        bit               dropped;
        sched_result_t    expected_results[$];
        int               errors;
        int               batches;
        int               overflow_batches;
        int               checked;

        function new();
            held = 0;
            dropped = 0;
            errors = 0;
            batches = 0;
            overflow_batches = 0;
            checked = 0;
        endfunction

        // one accepted input beat
        function void note_record(bit [BURST_W-1:0] burst, bit [PRIO_W-1:0] prio, bit last);
            sched_result_t r;
            bit [PID_W-1:0] t_pid;
            bit [BURST_W-1:0] t_burst;
            bit [PRIO_W-1:0] t_prio;
            int unsigned wait_acc;
            int unsigned ta;
            int unsigned tot_w;
            int unsigned tot_t;
            if (held < MAX_PROCS_DEF)
            begin
                pid_tab[held] = PID_W'(held + 1);
                burst_tab[held] = burst;
                prio_tab[held] = prio;
                held++;
            end
            else
                dropped = 1;
            if (!last)
                return;
            // exchange sort, ties resolved exactly as the hardware does
            for (int i = 0; i + 1 < held; i++)
                for (int j = i + 1; j < held; j++)
                    if (prio_tab[i] > prio_tab[j])
                    begin
                        t_pid = pid_tab[i];
                        t_burst = burst_tab[i];
                        t_prio = prio_tab[i];
                        pid_tab[i] = pid_tab[j];
                        burst_tab[i] = burst_tab[j];
                        prio_tab[i] = prio_tab[j];
                        pid_tab[j] = t_pid;
                        burst_tab[j] = t_burst;
                        prio_tab[j] = t_prio;
                    end
            wait_acc = 0;
            tot_w = 0;
            tot_t = 0;
            for (int k = 0; k < held; k++)
            begin
                ta = wait_acc + burst_tab[k];
                if (ta > 32'hFFFFF)
                    ta = 32'hFFFFF;
                tot_w = tot_w + wait_acc;
                if (tot_w > 32'hFFFFFF)
                    tot_w = 32'hFFFFFF;
                tot_t = tot_t + ta;
                if (tot_t > 32'hFFFFFF)
                    tot_t = 32'hFFFFFF;
                r.pid = pid_tab[k];
                r.burst = burst_tab[k];
                r.prio = prio_tab[k];
                r.wait_t = TIME_W'(wait_acc);
                r.turnaround = TIME_W'(ta);
                r.total_wait = TOT_W'(tot_w);
                r.total_turn = TOT_W'(tot_t);
                r.last = (k + 1 == held);
                r.overflow = dropped;
                expected_results.push_back(r);
                wait_acc = ta;
            end
            batches++;
            if (dropped)
                overflow_batches++;
            held = 0;
            dropped = 0;
        endfunction

        function void cmp_field(string tag, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, tag, exp_v, act_v);
            end
        endfunction

        // one accepted output beat
        function void check_result(logic [OUT_DATA_W-1:0] data, logic tlast, logic tuser);
            sched_result_t e;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual %0h", $time, data);
                return;
            end
            e = expected_results.pop_front();
            checked++;
            cmp_field("proc_id", e.pid, data[4:0]);
            cmp_field("burst_out", e.burst, data[20:5]);
            cmp_field("prio_out", e.prio, data[28:21]);
            cmp_field("wait_time", e.wait_t, data[48:29]);
            cmp_field("turnaround", e.turnaround, data[68:49]);
            cmp_field("total_wait", e.total_wait, data[92:69]);
            cmp_field("total_turnaround", e.total_turn, data[116:93]);
            cmp_field("last", e.last, tlast);
            cmp_field("overflow", e.overflow, tuser);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    sched_scoreboard sb;
    int  records_sent;
    bit  tx_steady;
    int  rx_free = 0;
    int  rx_stall = 0;
    int  rx_roll;
    int  idle_cycles = 0;

    priority_schedule_times DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 0;

    always #6 clk = ~clk;

    task automatic send_record(input bit [BURST_W-1:0] burst, input bit [PRIO_W-1:0] prio,
                               input bit last);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_steady || roll < 60)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {prio, burst};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_record(burst, prio, last);
        records_sent++;
    endtask

    task automatic send_batch(input int n, input bit tie_prios);
        bit [BURST_W-1:0] burst;
        int roll;
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                burst = '1;
            else if (roll == 1)
                burst = '0;
            else
                burst = BURST_W'($urandom_range(0, 65535));
            send_record(burst,
                        tie_prios ? PRIO_W'($urandom_range(0, 3))
                                  : PRIO_W'($urandom_range(0, 255)),
                        i == n - 1);
        end
        tx_steady = 0;
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver side: random back-pressure with free-running stretches
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser);
        if (rx_free > 0)
        begin
            rx_free--;
            m_tready <= 1;
        end
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 5)
                rx_free = $urandom_range(20, 60);
            else if (rx_roll < 25)
                rx_stall = $urandom_range(1, 3);
            else if (rx_roll < 30)
                rx_stall = $urandom_range(10, 40);
            m_tready <= (rx_roll < 5 || rx_roll >= 30);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        records_sent = 0;
        tx_steady = 0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // single-record batch
        send_record(16'hFFFF, 8'h00, 1);
        // equal priorities keep the exchange-sort order
        send_record(16'h0000, 8'h07, 0);
        send_record(16'h0001, 8'h07, 0);
        send_record(16'h8000, 8'h07, 0);
        send_record(16'h0005, 8'h07, 1);
        // table overflow, maximal bursts, last record itself dropped
        for (int i = 0; i < 18; i++)
            send_record(16'hFFFF, (i == 0) ? 8'hFF : 8'hFF - 8'(i * 15), i == 17);

        drain_results();

        while (records_sent < 23 + RANDOM_RECORDS)
        begin
            n = $urandom_range(0, 9);
            if (n < 7)
                n = $urandom_range(1, MAX_PROCS_DEF);
            else if (n < 8)
                n = MAX_PROCS_DEF;
            else
                n = $urandom_range(MAX_PROCS_DEF + 1, MAX_PROCS_DEF + 4);
            send_batch(n, $urandom_range(0, 2) == 0);
        end
        s_tvalid <= 0;
        s_tlast <= 0;

        drain_results();
        repeat (20) @(posedge clk);
        $display("Covered %0d batches (%0d with dropped records), %0d records in,",
                 sb.batches, sb.overflow_batches, records_sent);
        $display("%0d result beats checked under random stalls on both sides", sb.checked);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
